>>> hw/rtl/circq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package circq_pkg;

  // Queue geometry.
  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;

  // Command queue between the front and the back.
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  // Result queue at the output.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Command codes of the kind field.
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_DUMP    = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } result_t;

  // Decoded operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // Advance a ring index by one position.
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/circq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module circq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/circq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module circq_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire circq_pkg::item_t item_i,
  output logic                  cmd_valid_o,
  output circq_pkg::cmd_t       cmd_o,
  input  wire logic             cmd_ready_i
);
  import circq_pkg::*;

  cmd_t               mem_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t               decoded;
  logic               keep;
  logic               store;
  logic               take;

  // Decode the command; the unused code is accepted and dropped here.
  always_comb begin
    decoded.value = item_i.value;
    decoded.op    = OP_ENQ;
    keep          = 1'b1;
    case (item_i.kind)
      KIND_ENQUEUE: decoded.op = OP_ENQ;
      KIND_DEQUEUE: decoded.op = OP_DEQ;
      KIND_DUMP:    decoded.op = OP_DUMP;
      default:      keep       = 1'b0;
    endcase
  end

  assign full        = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
  assign store       = push && !full && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign take        = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (store) begin
      wr_ptr_d = (wr_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (store && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (take && !store) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[wr_ptr_q] <= decoded;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/circq_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module circq_outq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire circq_pkg::result_t        push_data_i,
  input  wire logic                      pop,
  output logic                           empty,
  output circq_pkg::result_t             result_o,
  output logic [circq_pkg::OQ_CNT_W-1:0] level_o
);
  import circq_pkg::*;

  result_t             mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                take;

  assign empty    = (cnt_q == '0);
  assign take     = pop && !empty;
  assign result_o = mem_q[rd_ptr_q];
  assign level_o  = cnt_q;

  // The back only pushes when it holds a credit, so no overflow check here.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (take && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/circq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module circq_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  wire circq_pkg::cmd_t           cmd_i,
  output logic                           cmd_ready_o,
  input  wire logic [circq_pkg::OQ_CNT_W-1:0] oq_level_i,
  output logic                           res_valid_o,
  output circq_pkg::result_t             res_o
);
  import circq_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_DUMP = 2'b10
  } back_state_e;

  // Second stage: what the result will be once the read data is back.
  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic       from_ram;
  } stage_t;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic              occ_q, occ_d;
  logic [IDX_W-1:0]  dump_idx_q, dump_idx_d;
  logic              s2_valid_q, s2_valid_d;
  stage_t            s2_q, s2_d;
  logic              credit;
  logic              is_full;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  // A result may issue only if the output queue has room for it and the one in flight.
  assign credit  = (({1'b0, oq_level_i} + (OQ_CNT_W + 1)'(s2_valid_q))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign is_full = occ_q && (next_index(tail_q) == head_q);

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    dump_idx_d  = dump_idx_q;
    s2_valid_d  = 1'b0;
    s2_d        = '{status: STATUS_OK, last: 1'b1, from_ram: 1'b0};
    we          = 1'b0;
    waddr       = tail_q;
    re          = 1'b0;
    raddr       = head_q;
    cmd_ready_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = credit;
        if (cmd_valid_i && credit) begin
          s2_valid_d = 1'b1;
          case (cmd_i.op)
            OP_ENQ: begin
              if (is_full) begin
                s2_d.status = STATUS_FULL;
              end else if (!occ_q) begin
                head_d = '0;
                tail_d = '0;
                occ_d  = 1'b1;
                we     = 1'b1;
                waddr  = '0;
              end else begin
                tail_d = next_index(tail_q);
                we     = 1'b1;
                waddr  = next_index(tail_q);
              end
            end
            OP_DEQ: begin
              if (!occ_q) begin
                s2_d.status = STATUS_EMPTY;
              end else begin
                re            = 1'b1;
                s2_d.from_ram = 1'b1;
                if (head_q == tail_q) begin
                  head_d = '0;
                  tail_d = '0;
                  occ_d  = 1'b0;
                end else begin
                  head_d = next_index(head_q);
                end
              end
            end
            OP_DUMP: begin
              if (!occ_q) begin
                s2_d.status = STATUS_EMPTY;
              end else begin
                re            = 1'b1;
                s2_d.from_ram = 1'b1;
                if (head_q != tail_q) begin
                  s2_d.last  = 1'b0;
                  dump_idx_d = next_index(head_q);
                  state_d    = BK_DUMP;
                end
              end
            end
            default: s2_valid_d = 1'b0;
          endcase
        end
      end
      BK_DUMP: begin
        if (credit) begin
          re            = 1'b1;
          raddr         = dump_idx_q;
          s2_valid_d    = 1'b1;
          s2_d.from_ram = 1'b1;
          s2_d.last     = (dump_idx_q == tail_q);
          if (dump_idx_q == tail_q) begin
            state_d = BK_IDLE;
          end else begin
            dump_idx_d = next_index(dump_idx_q);
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= 1'b0;
      dump_idx_q <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      dump_idx_q <= dump_idx_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  // Word storage of the ring.
  circq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Assemble the result once the read word is out of the RAM.
  assign res_valid_o   = s2_valid_q;
  assign res_o.status  = s2_q.status;
  assign res_o.data    = s2_q.from_ram ? rdata : '0;
  assign res_o.last    = s2_q.last;

endmodule

`default_nettype wire

>>> hw/rtl/circular_queue_with_dump.sv
// Circular queue of signed 32-bit words with enqueue, dequeue and dump commands.
// Input channel: drive item_i and raise push; the word is taken at a clock edge
// where push is high and full is low. Command code 3 is taken and ignored.
// Result channel: while empty is low, result_o holds the oldest result; raise
// pop to take it. Every command but code 3 gives one result, except a dump of
// a non-empty queue, which gives one result per stored word, oldest first, with
// last set only on the newest one.
// An accepted command passes through the command queue, the registered stage
// of the back end, which reads the word RAM, and the result queue before its
// first result shows on result_o. While the result queue has room the back end
// issues one result per cycle; a dump reads one stored word per result.
// A two-word command queue and a four-word result queue decouple the sides:
// when pop stays low the result queue fills, the back end stops issuing, then
// the command queue fills and full rises; nothing is lost.
// Reset (rst_ni low, asynchronous) empties both queues and the ring; stored
// words are not cleared, but only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_with_dump (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire circq_pkg::item_t   item_i,
  output logic                    empty,
  input  wire logic               pop,
  output circq_pkg::result_t      result_o
);
  import circq_pkg::*;

  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_ready;
  logic                res_valid;
  result_t             res;
  logic [OQ_CNT_W-1:0] oq_level;

  // Accept and decode commands.
  circq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  // Carry out commands on the ring.
  circq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .oq_level_i (oq_level),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Buffer results for the receiver.
  circq_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop        (pop),
    .empty      (empty),
    .result_o   (result_o),
    .level_o    (oq_level)
  );

endmodule

`default_nettype wire

>>> tb/tb_circular_queue_with_dump.sv
`timescale 1ns / 1ps

module tb_circular_queue_with_dump;
  import circq_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  // Command code that the block takes and ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  item_t   item_i = '0;
  logic    full;
  logic    empty;
  result_t result_o;

  // Local copy of the ring, updated as each command word is accepted.
  logic signed [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]         ring_head;
  logic [IDX_W-1:0]         ring_tail;
  logic                     ring_busy;

  result_t pending_results [$];
  int      fail_count = 0;
  int      stall_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  circular_queue_with_dump DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1);
  endfunction

  function automatic result_t make_result(input logic [1:0] status,
                                          input logic [DATA_W-1:0] data,
                                          input logic last);
    result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  // Work out the results of one command word and advance the local ring.
  task automatic predict_command(input item_t w);
    logic [IDX_W-1:0] i;
    int               n;
    logic             final_word;
    case (w.kind)
      KIND_ENQUEUE: begin
        if (ring_busy && ring_step(ring_tail) == ring_head) begin
          pending_results.push_back(make_result(STATUS_FULL, '0, 1'b1));
        end else begin
          if (!ring_busy) begin
            ring_head = '0;
            ring_tail = '0;
            ring_busy = 1'b1;
          end else begin
            ring_tail = ring_step(ring_tail);
          end
          ring_words[ring_tail] = w.value;
          pending_results.push_back(make_result(STATUS_OK, '0, 1'b1));
        end
      end
      KIND_DEQUEUE: begin
        if (!ring_busy) begin
          pending_results.push_back(make_result(STATUS_EMPTY, '0, 1'b1));
        end else begin
          pending_results.push_back(make_result(STATUS_OK, ring_words[ring_head], 1'b1));
          if (ring_head == ring_tail) begin
            ring_head = '0;
            ring_tail = '0;
            ring_busy = 1'b0;
          end else begin
            ring_head = ring_step(ring_head);
          end
        end
      end
      KIND_DUMP: begin
        if (!ring_busy) begin
          pending_results.push_back(make_result(STATUS_EMPTY, '0, 1'b1));
        end else begin
          i = ring_head;
          for (n = 0; n < DEPTH; n++) begin
            final_word = (i == ring_tail) || (n == DEPTH - 1);
            pending_results.push_back(make_result(STATUS_OK, ring_words[i], final_word));
            if (final_word) break;
            i = ring_step(i);
          end
        end
      end
      default: begin
        // The unused code is taken and ignored.
      end
    endcase
  endtask

  // Offer one command word, idling first at random, and wait until it is taken.
  task automatic send_command(input logic [1:0] kind, input logic [DATA_W-1:0] value);
    item_t w;
    w.kind  = kind;
    w.value = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (full);
    predict_command(w);
  endtask

  // Hold the sender back until every expected result has come out.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly random words, with the extremes and sign patterns mixed in.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Dequeue and dump on an empty queue, and the unused command code.
  task automatic test_empty_queue();
    send_command(KIND_DEQUEUE, 32'hffff_ffff);
    send_command(KIND_DUMP, 32'h0000_0000);
    send_command(KIND_UNUSED, 32'h1234_5678);
    send_command(KIND_DEQUEUE, 32'h0000_0000);
  endtask

  // Fill with extreme words, overflow, dump, wrap the ring and drain it.
  task automatic test_fill_wrap_drain();
    logic [DATA_W-1:0] extremes [DEPTH];
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'hdead_beef};
    for (int k = 0; k < DEPTH; k++) send_command(KIND_ENQUEUE, extremes[k]);
    send_command(KIND_ENQUEUE, 32'h0bad_f00d);
    send_command(KIND_DUMP, 32'hffff_ffff);
    send_command(KIND_DEQUEUE, 32'h0000_0000);
    send_command(KIND_ENQUEUE, 32'hc0ff_ee00);
    send_command(KIND_DUMP, 32'h0000_0000);
    for (int k = 0; k <= DEPTH; k++) send_command(KIND_DEQUEUE, $urandom);
    send_command(KIND_ENQUEUE, 32'h8000_0001);
    send_command(KIND_DUMP, $urandom);
  endtask

  // Random commands in segments that lean toward filling or toward draining.
  task automatic test_random_mix(input int count);
    int  roll;
    int  enq_pct;
    for (int k = 0; k < count; k++) begin
      if (k % 10 == 0) enq_pct = $urandom_range(0, 1) ? 70 : 25;
      roll = $urandom_range(0, 99);
      if (roll < 4)
        send_command(KIND_UNUSED, $urandom);
      else if (roll < 19)
        send_command(KIND_DUMP, $urandom);
      else if ($urandom_range(0, 99) < enq_pct)
        send_command(KIND_ENQUEUE, pick_word());
      else
        send_command(KIND_DEQUEUE, $urandom);
    end
  endtask

  // Check each accepted result word and drive pop for the next cycle.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual status %0d data %0d last %0d",
                   $time, result_o.status, result_o.data, result_o.last);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_o.status !== want.status ||
              result_o.data !== want.data ||
              result_o.last !== want.last) begin
            fail_count++;
            if (result_o.status !== want.status)
              $display("%0t: status mismatch, expected %0d actual %0d",
                       $time, want.status, result_o.status);
            if (result_o.data !== want.data)
              $display("%0t: data mismatch, expected %0d actual %0d",
                       $time, want.data, result_o.data);
            if (result_o.last !== want.last)
              $display("%0t: last mismatch, expected %0d actual %0d",
                       $time, want.last, result_o.last);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    ring_head = '0;
    ring_tail = '0;
    ring_busy = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 54;
    test_empty_queue();
    test_fill_wrap_drain();
    test_random_mix(40);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 34;
    test_random_mix(40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(40);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/circq_pkg.sv
hw/rtl/circq_ram.sv
hw/rtl/circq_front.sv
hw/rtl/circq_outq.sv
hw/rtl/circq_back.sv
hw/rtl/circular_queue_with_dump.sv
tb/tb_circular_queue_with_dump.sv
